/* src/ssch_pkg.sv */
// Shared constants and types for the slot scheduler.
// No dependencies; imported by the top level.
package ssch_pkg;

  // Default sizing, handed to the top level parameters
  localparam int SLOTS_DEF     = 16;
  localparam int WAIT_BITS_DEF = 16;

  // Fixed field widths
  localparam int SLOT_IN_W = 4;
  localparam int PRIO_W    = 8;

  // Command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_SCHED  = 1'b1;

  // Scheduling mode codes
  localparam logic MODE_RR    = 1'b0;
  localparam logic MODE_AGING = 1'b1;

  // Configuration register indexes
  localparam logic REG_SCHED_MODE = 1'b0;

  // Per-slot attributes as kept in the attribute table
  typedef struct packed {
    logic              occupied;
    logic              blocked;
    logic [PRIO_W-1:0] prio;
  } attr_t;

  localparam int ATTR_W = $bits(attr_t);

endpackage

/* src/ssch_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/slot_scheduler_rr_aging_unit.sv */
// Slot scheduler top level: slot tables, scan sequencer, shared ratio multiplier.
// Depends on ssch_pkg and ssch_ram.
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_stall     cmd, slot, occupied, blocked, prio_value
// out       output     out_valid / out_stall   chosen_slot, found
// cfg       input      APB psel/penable/pwrite paddr, pwdata, prdata (sched_mode)
//
// An update item is written into the attribute RAM at its accept edge.
// A schedule item scans the table one slot at a time: a RAM read step (S_RD), then an
// evaluate step (S_EV) per slot, plus the multiplier steps S_MA and S_MB for an aging slot
// that needs the shared multiplier for both cross products (never the first eligible slot).
// Round-robin stops at the first eligible slot; aging scans every slot.
// Reset is synchronous; per-entry valid bits make never-written entries read as zero,
// so no clearing pass is needed. in_stall is high while a schedule item is in work and
// while a finished result cannot enter a full, stalled output register.
module slot_scheduler_rr_aging_unit #(
  parameter int SLOTS     = ssch_pkg::SLOTS_DEF,
  parameter int WAIT_BITS = ssch_pkg::WAIT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [ssch_pkg::SLOT_IN_W-1:0]  slot,
  input  logic                            occupied,
  input  logic                            blocked,
  input  logic [ssch_pkg::PRIO_W-1:0]     prio_value,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ssch_pkg::SLOT_IN_W-1:0]  chosen_slot,
  output logic                            found,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import ssch_pkg::*;

  localparam int SW  = $clog2(SLOTS);
  localparam int MPW = WAIT_BITS + PRIO_W;
  localparam logic [SW:0]          SLOTS_X  = (SW+1)'(SLOTS);
  localparam logic [SW-1:0]        LAST_K   = SW'(SLOTS - 1);
  localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;

  // Sequencer state codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_MA   = 3'd3;
  localparam logic [2:0] S_MB   = 3'd4;
  localparam logic [2:0] S_PUT  = 3'd5;

  logic [2:0]           state, state_next;
  logic                 sched_mode;
  logic [SW-1:0]        ptr;
  logic [SW-1:0]        k;
  logic [SW-1:0]        cur_idx;
  logic [WAIT_BITS-1:0] cur_wait;
  logic [PRIO_W-1:0]    cur_prio;
  logic [SW-1:0]        best_idx;
  logic [WAIT_BITS-1:0] best_wait;
  logic [PRIO_W-1:0]    best_prio;
  logic                 have;
  logic [MPW-1:0]       prod_a;
  logic [SLOTS-1:0]     attr_valid;
  logic [SLOTS-1:0]     wait_valid;

  // ---------------------------------------------------------------------------
  // Configuration port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_SCHED_MODE);
  assign prdata = (paddr[2] == REG_SCHED_MODE) ? {31'b0, sched_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode <= MODE_RR;
    end else if (cfg_we) begin
      sched_mode <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes
  logic in_acc, out_free;
  assign in_stall = rst || (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // ---------------------------------------------------------------------------
  // Slot tables
  logic            attr_we;
  logic [SW-1:0]   attr_waddr;
  attr_t           attr_wdata, attr_rdata, attr_cur;
  logic            wait_we;
  logic [SW-1:0]   wait_waddr;
  logic [WAIT_BITS-1:0] wait_wdata, wait_rdata, wait_cur;
  logic [SW-1:0]   rd_addr;

  assign attr_we    = in_acc && (cmd == CMD_UPDATE) && (32'(slot) < 32'(SLOTS));
  assign attr_waddr = SW'(slot);
  assign attr_wdata = '{occupied: occupied, blocked: blocked, prio: prio_value};

  ssch_ram #(.WIDTH(ATTR_W), .DEPTH(SLOTS)) u_attr_ram (
    .clk   (clk),
    .we    (attr_we),
    .waddr (attr_waddr),
    .wdata (attr_wdata),
    .raddr (rd_addr),
    .rdata (attr_rdata)
  );

  ssch_ram #(.WIDTH(WAIT_BITS), .DEPTH(SLOTS)) u_wait_ram (
    .clk   (clk),
    .we    (wait_we),
    .waddr (wait_waddr),
    .wdata (wait_wdata),
    .raddr (rd_addr),
    .rdata (wait_rdata)
  );

  // never-written entries read as zero
  assign attr_cur = attr_valid[cur_idx] ? attr_rdata : '0;
  assign wait_cur = wait_valid[cur_idx] ? wait_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr_valid <= '0;
      wait_valid <= '0;
    end else begin
      if (attr_we) attr_valid[attr_waddr] <= 1'b1;
      if (wait_we) wait_valid[wait_waddr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Scan address: round-robin starts at ptr, aging at slot 0
  logic [SW:0] addr_sum;
  assign addr_sum = {1'b0, (sched_mode == MODE_AGING) ? '0 : ptr} + {1'b0, k};
  assign rd_addr  = (addr_sum >= SLOTS_X) ? SW'(addr_sum - SLOTS_X) : SW'(addr_sum);

  // ---------------------------------------------------------------------------
  // Evaluate step
  logic                 elig, last;
  logic [WAIT_BITS-1:0] wait_inc;
  logic                 take_now, need_mul;
  logic [SW:0]          idx_inc;
  logic [SW-1:0]        ptr_next;

  assign elig     = attr_cur.occupied && !attr_cur.blocked;
  assign last     = (k == LAST_K);
  assign wait_inc = (wait_cur == WAIT_MAX) ? wait_cur : wait_cur + 1'b1;
  assign take_now = !have || ((best_prio != '0) && (attr_cur.prio == '0));
  assign need_mul = have && (best_prio != '0) && (attr_cur.prio != '0);
  assign idx_inc  = {1'b0, cur_idx} + 1'b1;
  assign ptr_next = (idx_inc == SLOTS_X) ? '0 : idx_inc[SW-1:0];

  // Shared multiplier: current wait x best prio, then best wait x current prio
  logic [WAIT_BITS-1:0] mul_w;
  logic [PRIO_W-1:0]    mul_p;
  logic [MPW-1:0]       prod;
  assign mul_w = (state == S_MA) ? cur_wait : best_wait;
  assign mul_p = (state == S_MA) ? best_prio : cur_prio;
  assign prod  = MPW'(mul_w) * MPW'(mul_p);

  // Waiting table writes: increment during the aging scan, clear the winner at the end
  logic put_go;
  assign put_go = (state == S_PUT) && out_free;

  always_comb begin
    wait_we    = 1'b0;
    wait_waddr = cur_idx;
    wait_wdata = wait_inc;
    if ((state == S_EV) && (sched_mode == MODE_AGING) && elig) begin
      wait_we = 1'b1;
    end else if (put_go && have && (sched_mode == MODE_AGING)) begin
      wait_we    = 1'b1;
      wait_waddr = best_idx;
      wait_wdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc && (cmd == CMD_SCHED)) state_next = S_RD;
      S_RD:   state_next = S_EV;
      S_EV: begin
        if (sched_mode == MODE_RR) begin
          state_next = (elig || last) ? S_PUT : S_RD;
        end else if (elig && need_mul) begin
          state_next = S_MA;
        end else begin
          state_next = last ? S_PUT : S_RD;
        end
      end
      S_MA:   state_next = S_MB;
      S_MB:   state_next = last ? S_PUT : S_RD;
      S_PUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr   <= '0;
      k     <= '0;
      have  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_acc && (cmd == CMD_SCHED)) begin
            k    <= '0;
            have <= 1'b0;
          end
        end
        S_EV: begin
          if (sched_mode == MODE_RR) begin
            if (elig) begin
              have <= 1'b1;
              ptr  <= ptr_next;
            end else if (!last) begin
              k <= k + 1'b1;
            end
          end else begin
            if (elig && take_now) have <= 1'b1;
            if (!(elig && need_mul) && !last) k <= k + 1'b1;
          end
        end
        S_MB: if (!last) k <= k + 1'b1;
        default: ;
      endcase
    end
  end

  // Scan datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_RD: cur_idx <= rd_addr;
      S_EV: begin
        cur_wait <= wait_inc;
        cur_prio <= attr_cur.prio;
        if (elig && ((sched_mode == MODE_RR) || take_now)) begin
          best_idx  <= cur_idx;
          best_wait <= wait_inc;
          best_prio <= attr_cur.prio;
        end
      end
      S_MA: prod_a <= prod;
      S_MB: begin
        // strictly larger ratio wins, so ties keep the lower index
        if (prod_a > prod) begin
          best_idx  <= cur_idx;
          best_wait <= cur_wait;
          best_prio <= cur_prio;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_go) begin
      found       <= have;
      chosen_slot <= have ? SLOT_IN_W'(best_idx) : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !(in_acc && cmd == CMD_SCHED)) |=> state == S_IDLE)
    else $error("sequencer left idle without a schedule item");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    attr_we |-> (state == S_IDLE && !wait_we))
    else $error("attribute write outside idle or alongside a waiting write");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, ptr} < SLOTS_X)
    else $error("round-robin pointer out of range");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> chosen_slot == '0)
    else $error("result without a winner carries a nonzero slot");

endmodule

/* tb/sv/slot_scheduler_rr_aging_unit_tb.sv */
// Self-checking testbench for slot_scheduler_rr_aging_unit: random and directed
// items, with its own slot-table predictor. Depends on ssch_pkg and the block's RTL.
module slot_scheduler_rr_aging_unit_tb;
  import ssch_pkg::*;

  localparam int SLOTS         = SLOTS_DEF;
  localparam int WAIT_BITS     = WAIT_BITS_DEF;
  // longest aging scan plus margin; used before config writes and at the end
  localparam int SETTLE_CYCLES = 4 * SLOTS + 8;
  localparam logic [2:0] ADDR_MODE   = 3'(4 * REG_SCHED_MODE);
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam int PHASE_ITEMS   = 150;
  localparam int PHASES        = 6;

  typedef struct packed {
    logic                 cmd;
    logic [SLOT_IN_W-1:0] slot;
    logic                 occupied;
    logic                 blocked;
    logic [PRIO_W-1:0]    prio;
  } sched_item_t;

  typedef struct packed {
    logic [SLOT_IN_W-1:0] slot;
    logic                 found;
  } pick_t;

  // Slot table mirror plus the queue of picks still owed by the block
  class pick_scoreboard;
    bit                 occ_tab [SLOTS];
    bit                 blk_tab [SLOTS];
    bit [PRIO_W-1:0]    prio_tab [SLOTS];
    bit [WAIT_BITS-1:0] wait_tab [SLOTS];
    bit [SLOT_IN_W-1:0] rr_next;
    bit                 aging_mode;
    pick_t              expected_picks [$];
    int                 picks_seen;

    function void set_mode(logic m);
      aging_mode = (m == MODE_AGING);
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction

    // exact cross-multiplied compare of waiting/priority; priority 0 is infinite
    function bit ratio_wins(int a, int b);
      longint unsigned pa, pb, wa, wb;
      pa = prio_tab[a];
      pb = prio_tab[b];
      wa = wait_tab[a];
      wb = wait_tab[b];
      if (pb == 0) return 1'b0;
      if (pa == 0) return 1'b1;
      return wa * pb > wb * pa;
    endfunction

    function pick_t predict_pick();
      pick_t p;
      int    best;
      int    idx;
      bit    have;
      p    = '0;
      best = 0;
      have = 1'b0;
      if (aging_mode) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (occ_tab[i] && !blk_tab[i]) begin
            if (wait_tab[i] != '1) wait_tab[i]++;
            if (!have || ratio_wins(i, best)) begin
              best = i;
              have = 1'b1;
            end
          end
        end
        if (have) wait_tab[best] = '0;
      end else begin
        for (int k = 0; k < SLOTS && !have; k++) begin
          idx = (int'(rr_next) + k) % SLOTS;
          if (occ_tab[idx] && !blk_tab[idx]) begin
            best = idx;
            have = 1'b1;
          end
        end
        if (have) rr_next = SLOT_IN_W'((best + 1) % SLOTS);
      end
      p.found = have;
      p.slot  = have ? SLOT_IN_W'(best) : '0;
      return p;
    endfunction

    function void note_item(sched_item_t it);
      if (it.cmd == CMD_UPDATE) begin
        // waiting count is left alone by an update
        occ_tab[it.slot]  = it.occupied;
        blk_tab[it.slot]  = it.blocked;
        prio_tab[it.slot] = it.prio;
      end else begin
        expected_picks.push_back(predict_pick());
      end
    endfunction

    function bit check_pick(logic [SLOT_IN_W-1:0] got_slot, logic got_found,
                            output string why);
      pick_t want;
      why = "";
      if (expected_picks.size() == 0) begin
        why = $sformatf("result with nothing pending: slot=%0d found=%b",
                        got_slot, got_found);
        return 1'b0;
      end
      want = expected_picks.pop_front();
      picks_seen++;
      if (got_found !== want.found)
        why = {why, $sformatf(" found got %b want %b;", got_found, want.found)};
      if (got_slot !== want.slot)
        why = {why, $sformatf(" chosen_slot got %0d want %0d;", got_slot, want.slot)};
      if (why != "") why = $sformatf("pick %0d:%s", picks_seen, why);
      return why == "";
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic                 cmd        = CMD_UPDATE;
  logic [SLOT_IN_W-1:0] slot       = '0;
  logic                 occupied   = 1'b0;
  logic                 blocked    = 1'b0;
  logic [PRIO_W-1:0]    prio_value = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [SLOT_IN_W-1:0] chosen_slot;
  logic                 found;
  logic                 psel       = 1'b0;
  logic                 penable    = 1'b0;
  logic                 pwrite     = 1'b0;
  logic [2:0]           paddr      = '0;
  logic [31:0]          pwdata     = '0;
  logic [31:0]          prdata;
  logic                 pready;

  pick_scoreboard sb;
  int             fail_count = 0;
  bit             tx_calm    = 1'b0;
  bit             rx_calm    = 1'b0;
  int             rx_hold    = 0;
  string          mismatch_text;

  slot_scheduler_rr_aging_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .slot(slot), .occupied(occupied), .blocked(blocked),
    .prio_value(prio_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .chosen_slot(chosen_slot), .found(found),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string why);
    fail_count++;
    $display("MISMATCH @%0t: %s", $time, why);
  endtask

  // Result side: check accepted picks, then stall in random bursts
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (!sb.check_pick(chosen_slot, found, mismatch_text)) report_mismatch(mismatch_text);
    end
    if (rst || rx_calm) begin
      rx_hold = 0;
      out_stall <= 1'b0;
    end else begin
      if (rx_hold == 0 && $urandom_range(0, 5) == 0) rx_hold = $urandom_range(1, 10);
      if (rx_hold != 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // One APB transfer; the bus returns to idle afterwards
  task automatic cfg_access(logic is_write, logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (is_write && addr == ADDR_MODE) sb.set_mode(data[0]);
    if (!is_write && prdata !== {31'd0, sb.aging_mode ? MODE_AGING : MODE_RR})
      report_mismatch($sformatf("sched_mode read back %h", prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sched_mode(logic m);
    cfg_access(1'b1, ADDR_MODE, ($urandom() & 32'hffff_fffe) | 32'(m));
    cfg_access(1'b0, ADDR_MODE, '0);
  endtask

  task automatic send_item(sched_item_t it);
    int gap;
    gap = (!tx_calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= it.cmd;
    slot       <= it.slot;
    occupied   <= it.occupied;
    blocked    <= it.blocked;
    prio_value <= it.prio;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  // Hold the sender until every pick is back, then let the scan settle
  task automatic drain_picks();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sched_item_t upd(int s, bit occ, bit blk, int p);
    sched_item_t it;
    it.cmd      = CMD_UPDATE;
    it.slot     = SLOT_IN_W'(s);
    it.occupied = occ;
    it.blocked  = blk;
    it.prio     = PRIO_W'(p);
    return it;
  endfunction

  function automatic sched_item_t random_item();
    sched_item_t it;
    int          r;
    it.cmd      = ($urandom_range(0, 99) < 45) ? CMD_SCHED : CMD_UPDATE;
    it.slot     = SLOT_IN_W'($urandom_range(0, SLOTS - 1));
    it.occupied = ($urandom_range(0, 9) < 7);
    it.blocked  = ($urandom_range(0, 3) == 0);
    // bias toward infinite, max and small priorities so ties show up
    r = $urandom_range(0, 9);
    if (r == 0)     it.prio = '0;
    else if (r == 1) it.prio = '1;
    else if (r < 5)  it.prio = PRIO_W'($urandom_range(1, 4));
    else             it.prio = PRIO_W'($urandom_range(0, 255));
    return it;
  endfunction

  initial begin
    sched_item_t pick_req;
    int          settle;
    sb = new;
    pick_req = random_item();
    pick_req.cmd = CMD_SCHED;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // mode register: upper data bits ignored, unused address has no effect
    cfg_access(1'b1, ADDR_MODE, 32'hffff_fffe);
    cfg_access(1'b1, ADDR_UNUSED, 32'hffff_ffff);
    cfg_access(1'b0, ADDR_MODE, '0);

    // round-robin: empty table, blocked and free slots skipped, pointer wrap
    send_item(pick_req);
    send_item(upd(0, 1, 0, 0));
    send_item(upd(15, 1, 0, 255));
    send_item(upd(7, 1, 1, 128));
    send_item(upd(3, 0, 1, 85));
    repeat (3) send_item(pick_req);
    send_item(upd(7, 1, 0, 1));
    send_item(pick_req);
    drain_picks();

    // aging: infinite priority wins, lowest index among infinite, then no eligible slot
    set_sched_mode(MODE_AGING);
    send_item(pick_req);
    send_item(upd(5, 1, 0, 0));
    send_item(pick_req);
    send_item(upd(0, 0, 0, 0));
    send_item(upd(5, 0, 1, 0));
    send_item(upd(2, 1, 0, 1));
    repeat (3) send_item(pick_req);
    send_item(upd(7, 0, 0, 1));
    send_item(upd(15, 1, 1, 255));
    send_item(upd(2, 0, 0, 1));
    send_item(pick_req);
    drain_picks();

    // random phases, alternating policy; two phases run with no idling
    for (int ph = 0; ph < PHASES; ph++) begin
      set_sched_mode((ph % 2 == 1) ? MODE_AGING : MODE_RR);
      tx_calm = (ph == 2 || ph == PHASES - 1);
      rx_calm = tx_calm;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((ph == 1 || ph == 4) && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
        end
        send_item(random_item());
      end
      if (ph != PHASES - 1) drain_picks();
    end

    // final drain, bounded
    in_valid <= 1'b0;
    settle = 0;
    while (sb.pending() != 0 && settle < 20000) begin
      @(posedge clk);
      settle++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      report_mismatch($sformatf("%0d schedule items never answered", sb.pending()));

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
